FILE: design/ssrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sorter package
// Request types, microcode control word, status flags and the control store.
// ----------------------------------------------------------------------------
package ssrt_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
  } out_req_t;

  localparam int unsigned UPC_W = 4;

  typedef enum logic [3:0] {
    A_NOP,
    A_LOAD,
    A_SELINIT,
    A_BVAL,
    A_RDSCAN,
    A_CMP,
    A_SWAPRD,
    A_SWAPW1,
    A_SWAPW2,
    A_EMINIT,
    A_EMRD,
    A_EMLD,
    A_CLEAR
  } act_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_WAIT_IN,
    C_POS_DONE,
    C_SCAN_MORE,
    C_OUT_BUSY,
    C_EMIT_MORE
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cnd;
    logic [UPC_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    logic last_acc;
    logic pos_done;
    logic scan_more;
    logic emit_more;
    logic out_busy;
  } stat_t;

  localparam logic [UPC_W-1:0] S_LOAD    = UPC_W'(0);
  localparam logic [UPC_W-1:0] S_SELINIT = UPC_W'(1);
  localparam logic [UPC_W-1:0] S_BVAL    = UPC_W'(2);
  localparam logic [UPC_W-1:0] S_RDSCAN  = UPC_W'(3);
  localparam logic [UPC_W-1:0] S_CMP     = UPC_W'(4);
  localparam logic [UPC_W-1:0] S_SWAPRD  = UPC_W'(5);
  localparam logic [UPC_W-1:0] S_SWAPW1  = UPC_W'(6);
  localparam logic [UPC_W-1:0] S_SWAPW2  = UPC_W'(7);
  localparam logic [UPC_W-1:0] S_EMINIT  = UPC_W'(8);
  localparam logic [UPC_W-1:0] S_EMRD    = UPC_W'(9);
  localparam logic [UPC_W-1:0] S_EMLD    = UPC_W'(10);
  localparam logic [UPC_W-1:0] S_EMNEXT  = UPC_W'(11);
  localparam logic [UPC_W-1:0] S_CLEAR   = UPC_W'(12);

  // Control store: a jump is taken when the condition holds, else fall through.
  function automatic ctl_t ucode(input logic [UPC_W-1:0] addr);
    ctl_t c;
    c = '{act: A_NOP, cnd: C_ALWAYS, tgt: S_LOAD};
    unique case (addr)
      S_LOAD:    c = '{act: A_LOAD,    cnd: C_WAIT_IN,   tgt: S_LOAD};
      S_SELINIT: c = '{act: A_SELINIT, cnd: C_POS_DONE,  tgt: S_EMINIT};
      S_BVAL:    c = '{act: A_BVAL,    cnd: C_NEVER,     tgt: S_LOAD};
      S_RDSCAN:  c = '{act: A_RDSCAN,  cnd: C_NEVER,     tgt: S_LOAD};
      S_CMP:     c = '{act: A_CMP,     cnd: C_SCAN_MORE, tgt: S_RDSCAN};
      S_SWAPRD:  c = '{act: A_SWAPRD,  cnd: C_NEVER,     tgt: S_LOAD};
      S_SWAPW1:  c = '{act: A_SWAPW1,  cnd: C_NEVER,     tgt: S_LOAD};
      S_SWAPW2:  c = '{act: A_SWAPW2,  cnd: C_ALWAYS,    tgt: S_SELINIT};
      S_EMINIT:  c = '{act: A_EMINIT,  cnd: C_NEVER,     tgt: S_LOAD};
      S_EMRD:    c = '{act: A_EMRD,    cnd: C_NEVER,     tgt: S_LOAD};
      S_EMLD:    c = '{act: A_EMLD,    cnd: C_OUT_BUSY,  tgt: S_EMLD};
      S_EMNEXT:  c = '{act: A_NOP,     cnd: C_EMIT_MORE, tgt: S_EMRD};
      S_CLEAR:   c = '{act: A_CLEAR,   cnd: C_ALWAYS,    tgt: S_LOAD};
      default:   c = '{act: A_NOP,     cnd: C_ALWAYS,    tgt: S_LOAD};
    endcase
    return c;
  endfunction

endpackage

FILE: design/ssrt_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sorter sequencer
// Step counter over the control store with conditional jumps on status.
// ----------------------------------------------------------------------------
module ssrt_useq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssrt_pkg::stat_t stat_i,
  output ssrt_pkg::ctl_t  ctl_o
);

  logic [ssrt_pkg::UPC_W-1:0] upc_q, upc_d;
  ssrt_pkg::ctl_t             ctl;
  logic                       jump;

  assign ctl   = ssrt_pkg::ucode(upc_q);
  assign ctl_o = ctl;

  always_comb begin
    unique case (ctl.cnd)
      ssrt_pkg::C_NEVER:     jump = 1'b0;
      ssrt_pkg::C_ALWAYS:    jump = 1'b1;
      ssrt_pkg::C_WAIT_IN:   jump = !stat_i.last_acc;
      ssrt_pkg::C_POS_DONE:  jump = stat_i.pos_done;
      ssrt_pkg::C_SCAN_MORE: jump = stat_i.scan_more;
      ssrt_pkg::C_OUT_BUSY:  jump = stat_i.out_busy;
      ssrt_pkg::C_EMIT_MORE: jump = stat_i.emit_more;
      default:               jump = 1'b1;
    endcase
  end

  assign upc_d = jump ? ctl.tgt : upc_q + ssrt_pkg::UPC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ssrt_pkg::S_LOAD;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

FILE: design/ssrt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sorter datapath
// Element store, count, position/scan/best indexes and the running minimum.
// ----------------------------------------------------------------------------
module ssrt_dpath #(
  parameter int unsigned MAX_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssrt_pkg::ctl_t     ctl_i,
  input  logic               in_acc_i,
  input  ssrt_pkg::in_req_t  in_req_i,
  input  logic               out_busy_i,
  output ssrt_pkg::stat_t    stat_o,
  output logic signed [31:0] em_value_o,
  output logic               em_last_o
);

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);
  localparam int unsigned IW = $clog2(MAX_COUNT);

  logic signed [31:0] mem_q [MAX_COUNT];
  logic signed [31:0] rd_q;
  logic signed [31:0] bval_q, bval_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      scan_q, scan_d;
  logic [CW-1:0]      best_q, best_d;
  logic               we;
  logic [IW-1:0]      waddr;
  logic [IW-1:0]      raddr;
  logic signed [31:0] wdata;
  logic               not_full;

  assign not_full = cnt_q < CW'(MAX_COUNT);
  assign raddr    = (ctl_i.act == ssrt_pkg::A_RDSCAN) ? scan_q[IW-1:0] : pos_q[IW-1:0];

  always_comb begin
    cnt_d  = cnt_q;
    pos_d  = pos_q;
    scan_d = scan_q;
    best_d = best_q;
    bval_d = bval_q;
    we     = 1'b0;
    waddr  = pos_q[IW-1:0];
    wdata  = bval_q;
    unique case (ctl_i.act)
      ssrt_pkg::A_LOAD: begin
        pos_d = '0;
        if (in_acc_i && not_full) begin
          we    = 1'b1;
          waddr = cnt_q[IW-1:0];
          wdata = in_req_i.value;
          cnt_d = cnt_q + CW'(1);
        end
      end
      ssrt_pkg::A_SELINIT: begin
        best_d = pos_q;
        scan_d = pos_q + CW'(1);
      end
      ssrt_pkg::A_BVAL: bval_d = rd_q;
      ssrt_pkg::A_CMP: begin
        if (rd_q < bval_q) begin
          bval_d = rd_q;
          best_d = scan_q;
        end
        scan_d = scan_q + CW'(1);
      end
      ssrt_pkg::A_SWAPW1: begin
        we    = 1'b1;
        waddr = best_q[IW-1:0];
        wdata = rd_q;
      end
      ssrt_pkg::A_SWAPW2: begin
        we    = 1'b1;
        pos_d = pos_q + CW'(1);
      end
      ssrt_pkg::A_EMINIT: pos_d = '0;
      ssrt_pkg::A_EMLD: begin
        if (!out_busy_i) begin
          pos_d = pos_q + CW'(1);
        end
      end
      ssrt_pkg::A_CLEAR: cnt_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q   <= mem_q[raddr];
    bval_q <= bval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pos_q  <= '0;
      scan_q <= '0;
      best_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pos_q  <= pos_d;
      scan_q <= scan_d;
      best_q <= best_d;
    end
  end

  assign stat_o.last_acc  = in_acc_i && in_req_i.last;
  assign stat_o.pos_done  = (pos_q + CW'(1)) >= cnt_q;
  assign stat_o.scan_more = (scan_q + CW'(1)) < cnt_q;
  assign stat_o.emit_more = pos_q < cnt_q;
  assign stat_o.out_busy  = out_busy_i;

  assign em_value_o = rd_q;
  assign em_last_o  = (pos_q + CW'(1)) == cnt_q;

endmodule

FILE: design/selection_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sorter
// Stores a list of signed words, sorts it ascending by selection sort under
// microcode control, and streams the sorted list out.
// ----------------------------------------------------------------------------
//  channel | direction | payload    | handshake
//  in      | input     | in_req_i   | in_valid_i / in_stall_o
//  out     | output    | out_req_o  | out_valid_o / out_stall_i
//
//  Loading takes one request per cycle; the store holds MAX_COUNT elements.
//  After the last request, the list is sorted with one store read per compare
//  step, then emitted one result at a time, waiting out any output stall, with
//  a setup step before emission and a clear step after it.
//  Input stalls from the last request until emission ends.
//  Reset clears the count and sequencer; the store itself is never cleared.
// ----------------------------------------------------------------------------
module selection_sorter_top #(
  parameter int unsigned MAX_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ssrt_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ssrt_pkg::out_req_t out_req_o
);

  ssrt_pkg::ctl_t     ctl;
  ssrt_pkg::stat_t    stat;
  ssrt_pkg::out_req_t out_req_q;
  logic               out_valid_q, out_valid_d;
  logic               in_acc;
  logic               out_busy;
  logic               out_load;
  logic signed [31:0] em_value;
  logic               em_last;

  assign in_stall_o = ctl.act != ssrt_pkg::A_LOAD;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;
  assign out_load   = (ctl.act == ssrt_pkg::A_EMLD) && !out_busy;

  ssrt_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  ssrt_dpath #(
    .MAX_COUNT (MAX_COUNT)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .in_acc_i   (in_acc),
    .in_req_i   (in_req_i),
    .out_busy_i (out_busy),
    .stat_o     (stat),
    .em_value_o (em_value),
    .em_last_o  (em_last)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_req_q.value_res <= em_value;
      out_req_q.last_res  <= em_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_req_i.last) |=> in_stall_o)
    else $error("input taken after last request");

  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && em_last) |=> !stat.emit_more)
    else $error("last result flagged with elements still pending");

  a_no_load_while_sorting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> in_stall_o)
    else $error("result loaded while accepting input");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sorter testbench
// Streams lists of signed words into the sorter and checks every sorted word
// and end marker against a behavioral sort of the same list. Covers extreme
// values, duplicates, single-element lists and lists that overflow the store,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CAP        = 64;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int          RAND_ITEMS = 92;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  class sort_board;
    int unsigned capacity;
    logic signed [31:0] list_words[$];
    ssrt_pkg::out_req_t sorted_q[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned drops;
    int unsigned lists_done;
    int unsigned results_checked;

    function new(int unsigned cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction

    function void note_request(ssrt_pkg::in_req_t req);
      int best;
      logic signed [31:0] held;
      ssrt_pkg::out_req_t res;
      requests++;
      if (list_words.size() < capacity) begin
        list_words = {list_words, req.value};
      end else begin
        drops++;
      end
      if (req.last) begin
        for (int pos = 0; pos + 1 < list_words.size(); pos++) begin
          best = pos;
          for (int scan = pos + 1; scan < list_words.size(); scan++) begin
            if (list_words[scan] < list_words[best]) best = scan;
          end
          held = list_words[best];
          list_words[best] = list_words[pos];
          list_words[pos] = held;
        end
        foreach (list_words[k]) begin
          res.value_res = list_words[k];
          res.last_res  = (k == list_words.size() - 1);
          sorted_q = {sorted_q, res};
        end
        list_words.delete();
        lists_done++;
      end
    endfunction

    function void check_result(ssrt_pkg::out_req_t got);
      ssrt_pkg::out_req_t want;
      if (sorted_q.size() == 0) begin
        $error("unexpected result value_res=%0d last_res=%0b", got.value_res, got.last_res);
        mismatches++;
        return;
      end
      want = sorted_q.pop_front();
      results_checked++;
      if (got.value_res !== want.value_res) begin
        $error("value_res: expected %0d, got %0d", want.value_res, got.value_res);
        mismatches++;
      end
      if (got.last_res !== want.last_res) begin
        $error("last_res: expected %0b, got %0b", want.last_res, got.last_res);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  ssrt_pkg::in_req_t  in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  ssrt_pkg::out_req_t out_req_o;

  sort_board board;
  int unsigned idle_cycles;
  int in_quiet;
  int out_quiet;

  selection_sorter_top #(.MAX_COUNT(CAP)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // quiet > 0: a stretch with no idling
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      quiet = $urandom_range(4, 20);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [31:0] draw_value();
    unique case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic signed [31:0] v, input logic l);
    int gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{value: v, last: l};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_list(input int len);
    for (int i = 0; i < len; i++) send_request(draw_value(), i == len - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) board.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) board.check_result(out_req_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int gap;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      gap = draw_gap(out_quiet);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int len;
    int random_items;
    bit overflow_done;
    board      = new(CAP);
    in_quiet   = 0;
    out_quiet  = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element lists at both extremes
    send_request(WORD_MAX, 1'b1);
    send_request(WORD_MIN, 1'b1);
    // extremes mixed with duplicates and values around zero
    send_request(WORD_MAX, 1'b0);
    send_request(WORD_MIN, 1'b0);
    send_request(0, 1'b0);
    send_request(-1, 1'b0);
    send_request(1, 1'b0);
    send_request(WORD_MIN, 1'b0);
    send_request(WORD_MAX, 1'b1);
    // all equal
    send_request(5, 1'b0);
    send_request(5, 1'b0);
    send_request(5, 1'b1);
    // reverse order, then already sorted
    send_request(3, 1'b0);
    send_request(2, 1'b0);
    send_request(1, 1'b0);
    send_request(0, 1'b1);
    send_request(-7, 1'b0);
    send_request(9, 1'b1);
    drain();

    random_items  = 0;
    overflow_done = 1'b0;
    while (random_items < RAND_ITEMS) begin
      if (!overflow_done && random_items >= 10) begin
        // fills the store; the extra words and the closing one are dropped
        drain();
        len = CAP + 1 + $urandom_range(0, 2);
        overflow_done = 1'b1;
      end else begin
        if ($urandom_range(0, 7) == 0) begin
          len = $urandom_range(11, 30);
        end else begin
          len = $urandom_range(1, 10);
        end
        if (len > RAND_ITEMS - random_items) len = RAND_ITEMS - random_items;
      end
      send_list(len);
      random_items += len;
    end
    drain();
    repeat (20) @(posedge clk_i);

    $display("Sorted %0d lists from %0d requests (%0d dropped on a full store)",
             board.lists_done, board.requests, board.drops);
    $display("Checked %0d results, %0d mismatches", board.results_checked,
             board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: selection_sorter_top.f
design/ssrt_pkg.sv
design/ssrt_useq.sv
design/ssrt_dpath.sv
design/selection_sorter_top.sv
test/tb.sv
